[rtl/core/rbst_pkg.sv]
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared widths, register indexes and types for the ray/box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

   // fixed point format default
   localparam int FRAC_BITS_DEF = 16;

   // field widths
   localparam int COORD_W   = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int LIMIT_W   = 31;
   localparam int DIST_W    = 34;
   localparam int DIV_STEPS = 32;
   localparam int DIV_LAT   = DIV_STEPS + 1;

   // configuration registers
   localparam int CSR_IDX_W = 3;
   localparam int NUM_REGS  = 6;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_Z = 3'd5;

   // per request side data carried beside the dividers
   typedef struct packed {
      logic               valid;
      logic [2:0]         dzero;
      logic [2:0]         zok;
      logic [LIMIT_W-1:0] limit;
   } side_type;

endpackage

[rtl/core/rbst_if.sv]
// ----------------------------------------------------------------------------
// rbst request and response channels
// Valid/ready channels carrying a ray request and a slab test response.
// ----------------------------------------------------------------------------
interface rbst_req_if;
   logic        valid;
   logic        ready;
   logic signed [rbst_pkg::COORD_W-1:0] origin_x;
   logic signed [rbst_pkg::COORD_W-1:0] origin_y;
   logic signed [rbst_pkg::COORD_W-1:0] origin_z;
   logic signed [rbst_pkg::COORD_W-1:0] dir_x;
   logic signed [rbst_pkg::COORD_W-1:0] dir_y;
   logic signed [rbst_pkg::COORD_W-1:0] dir_z;
   logic [rbst_pkg::LIMIT_W-1:0]        ray_limit;
   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   ray_limit, input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 ray_limit, output ready);
endinterface

interface rbst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic [rbst_pkg::LIMIT_W-1:0] t_enter;
   logic [rbst_pkg::LIMIT_W-1:0] t_exit;
   modport source (output valid, hit, t_enter, t_exit, input ready);
   modport sink (input valid, hit, t_enter, t_exit, output ready);
endinterface

[rtl/core/rbst_div.sv]
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined signed divider, one quotient bit per stage, magnitude saturated
// at 2^32-1. Truncates toward zero.
// ----------------------------------------------------------------------------
module rbst_div #(
   parameter int NUM_W = rbst_pkg::DIFF_W + rbst_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic [NUM_W-1:0]                   num,
   input  logic [rbst_pkg::COORD_W-1:0]       den,
   input  logic                               neg,
   output logic signed [rbst_pkg::DIST_W-1:0] quo
);
   localparam int STEPS = rbst_pkg::DIV_STEPS;

   logic [STEPS:0]   rem_ff  [0:STEPS];
   logic [STEPS-1:0] low_ff  [0:STEPS];
   logic [STEPS-1:0] q_ff    [0:STEPS];
   logic [STEPS-1:0] den_ff  [0:STEPS];
   logic             neg_ff  [0:STEPS];
   logic             sat_ff  [0:STEPS];
   logic [STEPS-1:0] mag;

   // first stage: high part becomes the starting remainder, overflow check
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= (STEPS+1)'(num >> STEPS);
         low_ff[0] <= num[STEPS-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= neg;
         sat_ff[0] <= (NUM_W+1)'(num >> STEPS) >= (NUM_W+1)'(den);
      end
   end

   // restoring steps
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      logic [STEPS:0] trial;
      logic           ge;
      assign trial = {rem_ff[k-1][STEPS-1:0], low_ff[k-1][STEPS-1]};
      assign ge    = trial >= {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? trial - {1'b0, den_ff[k-1]} : trial;
            low_ff[k] <= {low_ff[k-1][STEPS-2:0], 1'b0};
            q_ff[k]   <= {q_ff[k-1][STEPS-2:0], ge};
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   // apply saturation and sign
   assign mag = sat_ff[STEPS] ? '1 : q_ff[STEPS];
   assign quo = neg_ff[STEPS] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});

endmodule

[rtl/core/ray_box_slab_test.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Slab method test of a ray against one axis aligned box held in registers.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  req_ch    in         origin xyz, direction xyz, ray_limit
//  rsp_ch    out        hit, t_enter, t_exit
//  csr_*     in         box corner writes, six 32-bit registers
//
// One request per cycle unless the response stalls; the core is built around
// six 32-step divider pipelines (one quotient bit per stage).
// Synchronous reset clears the box registers and all valid bits.
// A stalled response freezes the whole pipeline; req_ch.ready drops with it.
// Box registers must be written only while the pipeline is empty (unchecked).
module ray_box_slab_test #(
   parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   rbst_req_if.sink                          req_ch,
   rbst_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [rbst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rbst_pkg::COORD_W-1:0]      csr_wdata
);
   localparam int CW    = rbst_pkg::COORD_W;
   localparam int DW    = rbst_pkg::DIFF_W;
   localparam int TW    = rbst_pkg::DIST_W;
   localparam int LW    = rbst_pkg::LIMIT_W;
   localparam int NUM_W = DW + FRAC_BITS;
   localparam int LAT   = rbst_pkg::DIV_LAT;

   logic en;

   // box registers
   logic signed [CW-1:0] box_ff [0:rbst_pkg::NUM_REGS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rbst_pkg::NUM_REGS; i++) box_ff[i] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rbst_pkg::REG_MIN_X: box_ff[0] <= csr_wdata;
            rbst_pkg::REG_MIN_Y: box_ff[1] <= csr_wdata;
            rbst_pkg::REG_MIN_Z: box_ff[2] <= csr_wdata;
            rbst_pkg::REG_MAX_X: box_ff[3] <= csr_wdata;
            rbst_pkg::REG_MAX_Y: box_ff[4] <= csr_wdata;
            rbst_pkg::REG_MAX_Z: box_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance
   logic rsp_valid_ff;
   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // input stage: slab differences
   logic signed [CW-1:0] org [0:2];
   logic signed [CW-1:0] dir [0:2];
   assign org[0] = req_ch.origin_x;
   assign org[1] = req_ch.origin_y;
   assign org[2] = req_ch.origin_z;
   assign dir[0] = req_ch.dir_x;
   assign dir[1] = req_ch.dir_y;
   assign dir[2] = req_ch.dir_z;

   logic                 v0_ff;
   logic signed [DW-1:0] dmin_ff [0:2];
   logic signed [DW-1:0] dmax_ff [0:2];
   logic signed [CW-1:0] dir_ff  [0:2];
   logic [LW-1:0]        limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            dmin_ff[a] <= DW'(box_ff[a]) - DW'(org[a]);
            dmax_ff[a] <= DW'(box_ff[a+3]) - DW'(org[a]);
            dir_ff[a]  <= dir[a];
         end
         limit_ff <= req_ch.ray_limit;
      end
   end

   // dividers, two per axis
   logic signed [TW-1:0] t_min [0:2];
   logic signed [TW-1:0] t_max [0:2];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic [CW-1:0]    dmag;
      logic [DW-1:0]    nmin_mag;
      logic [DW-1:0]    nmax_mag;
      assign dmag     = dir_ff[a][CW-1] ? CW'(-dir_ff[a]) : CW'(dir_ff[a]);
      assign nmin_mag = dmin_ff[a][DW-1] ? DW'(-dmin_ff[a]) : DW'(dmin_ff[a]);
      assign nmax_mag = dmax_ff[a][DW-1] ? DW'(-dmax_ff[a]) : DW'(dmax_ff[a]);

      rbst_div #(.NUM_W(NUM_W)) u_div_min (
         .clock (clock),
         .en    (en),
         .num   ({nmin_mag, {FRAC_BITS{1'b0}}}),
         .den   (dmag),
         .neg   (dmin_ff[a][DW-1] ^ dir_ff[a][CW-1]),
         .quo   (t_min[a])
      );
      rbst_div #(.NUM_W(NUM_W)) u_div_max (
         .clock (clock),
         .en    (en),
         .num   ({nmax_mag, {FRAC_BITS{1'b0}}}),
         .den   (dmag),
         .neg   (dmax_ff[a][DW-1] ^ dir_ff[a][CW-1]),
         .quo   (t_max[a])
      );
   end

   // side data delay line matching the divider latency
   rbst_pkg::side_type side_ff [0:LAT-1];
   rbst_pkg::side_type side_in;

   always_comb begin
      side_in.valid = v0_ff;
      side_in.limit = limit_ff;
      for (int a = 0; a < 3; a++) begin
         side_in.dzero[a] = dir_ff[a] == '0;
         side_in.zok[a]   = (dmin_ff[a] <= 0) && (dmax_ff[a] >= 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) side_ff[i] <= '0;
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < LAT; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // order entry and exit per axis
   logic                 va_ff;
   logic                 oka_ff;
   logic signed [TW-1:0] ent_ff [0:2];
   logic signed [TW-1:0] ext_ff [0:2];
   logic signed [TW-1:0] lima_ff;
   logic signed [TW-1:0] lim_s;
   rbst_pkg::side_type   sd;

   assign sd    = side_ff[LAT-1];
   assign lim_s = $signed(TW'(sd.limit));

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= sd.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         oka_ff  <= &(sd.zok | ~sd.dzero);
         lima_ff <= lim_s;
         for (int a = 0; a < 3; a++) begin
            if (sd.dzero[a]) begin
               ent_ff[a] <= '0;
               ext_ff[a] <= lim_s;
            end else if (t_min[a] > t_max[a]) begin
               ent_ff[a] <= t_max[a];
               ext_ff[a] <= t_min[a];
            end else begin
               ent_ff[a] <= t_min[a];
               ext_ff[a] <= t_max[a];
            end
         end
      end
   end

   // narrow the interval
   logic                 vb_ff;
   logic                 okb_ff;
   logic signed [TW-1:0] lo_ff;
   logic signed [TW-1:0] hi_ff;
   logic signed [TW-1:0] lo_in;
   logic signed [TW-1:0] hi_in;

   always_comb begin
      lo_in = '0;
      hi_in = lima_ff;
      for (int a = 0; a < 3; a++) begin
         if (ent_ff[a] > lo_in) lo_in = ent_ff[a];
         if (ext_ff[a] < hi_in) hi_in = ext_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         okb_ff <= oka_ff;
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
      end
   end

   // response register
   logic          hit_ff;
   logic [LW-1:0] tent_ff;
   logic [LW-1:0] texit_ff;
   logic          hit_in;

   assign hit_in = okb_ff && (lo_ff <= hi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff   <= hit_in;
         tent_ff  <= hit_in ? lo_ff[LW-1:0] : '0;
         texit_ff <= hit_in ? hi_ff[LW-1:0] : '0;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.hit     = hit_ff;
   assign rsp_ch.t_enter = tent_ff;
   assign rsp_ch.t_exit  = texit_ff;

`ifndef NO_ASSERTIONS
   // a hit always carries an ordered interval
   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && hit_ff |-> tent_ff <= texit_ff)
      else $error("hit with t_enter above t_exit");

   // a miss carries zero distances
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !hit_ff |-> tent_ff == '0 && texit_ff == '0)
      else $error("miss with nonzero distances");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

   // a stalled pipeline keeps its response
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(hit_ff) && $stable(tent_ff) && $stable(vb_ff))
      else $error("pipeline moved while stalled");
`endif

endmodule
